// ----- rtl/core/ksl_pkg.sv -----
// shared types and constants for the key scanner with long press detection
package ksl_pkg;

    localparam int SCAN_W  = 8;
    localparam int HOLD_W  = 16;
    localparam int EVENT_W = 3;
    localparam int KEY_W   = 2;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 1'd1;

    localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST = 8'd20;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RST  = 16'd1000;
    localparam logic [HOLD_W-1:0] HOLD_LIMIT      = 16'd60000;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic LEVEL_PRESSED = 1'b0;

    localparam logic [KEY_W-1:0] KEY_NONE  = 2'd0;
    localparam logic [KEY_W-1:0] KEY_ONE   = 2'd1;
    localparam logic [KEY_W-1:0] KEY_TWO   = 2'd2;
    localparam logic [KEY_W-1:0] KEY_THREE = 2'd3;

    localparam logic [EVENT_W-1:0] EVT_NONE = 3'd0;
    localparam logic [EVENT_W-1:0] EVT_LONG = 3'd4;

    typedef struct packed {
        logic action;
        logic key1_level;
        logic key2_level;
        logic key3_level;
    } item_t;

    typedef struct packed {
        logic [SCAN_W-1:0] scan_period;
        logic [HOLD_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_code;
        logic [KEY_W-1:0]   sampled_key;
    } result_t;

endpackage

// ----- rtl/core/ksl_if.sv -----
// valid/ready channels for key words and result words
interface ksl_key_if;
    logic valid;
    logic ready;
    logic action;
    logic key1_level;
    logic key2_level;
    logic key3_level;

    modport source (output valid, output action, output key1_level, output key2_level,
                    output key3_level, input ready);
    modport sink (input valid, input action, input key1_level, input key2_level,
                  input key3_level, output ready);
endinterface

interface ksl_result_if;
    logic                         valid;
    logic                         ready;
    logic [ksl_pkg::EVENT_W-1:0]  event_code;
    logic [ksl_pkg::KEY_W-1:0]    sampled_key;

    modport source (output valid, output event_code, output sampled_key, input ready);
    modport sink (input valid, input event_code, input sampled_key, output ready);
endinterface

// ----- rtl/core/ksl_scan.sv -----
// scanner state: tick divider, key sampling, key three hold counter and pending event
module ksl_scan
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ksl_pkg::item_t   item,
    input  ksl_pkg::cfg_t    cfg,
    output ksl_pkg::result_t res
);

    logic [ksl_pkg::SCAN_W-1:0]  div_reg,  div_next;
    logic [ksl_pkg::KEY_W-1:0]   cur_reg,  cur_next;
    logic [ksl_pkg::KEY_W-1:0]   prev_reg, prev_next;
    logic [ksl_pkg::HOLD_W-1:0]  hold_reg, hold_next;
    logic                        long_reg, long_next;
    logic [ksl_pkg::EVENT_W-1:0] pend_reg, pend_next;

    logic [ksl_pkg::SCAN_W-1:0]  div_inc;
    logic [ksl_pkg::KEY_W-1:0]   prio_key;
    logic                        long_mid;
    logic [ksl_pkg::EVENT_W-1:0] code;

    always_comb
    begin
        if (item.key1_level == ksl_pkg::LEVEL_PRESSED)
            prio_key = ksl_pkg::KEY_ONE;
        else if (item.key2_level == ksl_pkg::LEVEL_PRESSED)
            prio_key = ksl_pkg::KEY_TWO;
        else if (item.key3_level == ksl_pkg::LEVEL_PRESSED)
            prio_key = ksl_pkg::KEY_THREE;
        else
            prio_key = ksl_pkg::KEY_NONE;
    end

    assign div_inc = div_reg + ksl_pkg::SCAN_W'(1);

    always_comb
    begin
        div_next  = div_reg;
        cur_next  = cur_reg;
        prev_next = prev_reg;
        hold_next = hold_reg;
        long_next = long_reg;
        pend_next = pend_reg;
        long_mid  = long_reg;
        code      = ksl_pkg::EVT_NONE;

        if (item.action == ksl_pkg::ACT_READ)
        begin
            code      = pend_reg;
            pend_next = ksl_pkg::EVT_NONE;
        end
        else
        begin
            // sampling stage
            div_next = div_inc;
            if (div_inc >= cfg.scan_period)
            begin
                div_next  = '0;
                prev_next = cur_reg;
                cur_next  = prio_key;
                if (cur_reg != ksl_pkg::KEY_NONE && prio_key == ksl_pkg::KEY_NONE)
                begin
                    // release of key three after a long press stays silent
                    if (cur_reg == ksl_pkg::KEY_THREE && long_reg)
                        long_mid = 1'b0;
                    else
                        pend_next = {1'b0, cur_reg};
                end
            end

            // hold stage for key three
            long_next = long_mid;
            if (item.key3_level != ksl_pkg::LEVEL_PRESSED)
            begin
                hold_next = '0;
            end
            else
            begin
                if (hold_reg < ksl_pkg::HOLD_LIMIT)
                    hold_next = hold_reg + ksl_pkg::HOLD_W'(1);
                if (hold_next >= cfg.long_press_ticks && !long_mid)
                begin
                    pend_next = ksl_pkg::EVT_LONG;
                    long_next = 1'b1;
                end
            end
        end
    end

    assign res.event_code  = code;
    assign res.sampled_key = cur_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= '0;
            cur_reg  <= ksl_pkg::KEY_NONE;
            prev_reg <= ksl_pkg::KEY_NONE;
            hold_reg <= '0;
            long_reg <= 1'b0;
            pend_reg <= ksl_pkg::EVT_NONE;
        end
        else if (step)
        begin
            div_reg  <= div_next;
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
            hold_reg <= hold_next;
            long_reg <= long_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ----- rtl/core/key_scan_long_press.sv -----
// top level: config registers, scanner state and two-entry result queue
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  keys     | in  | action, key1_level, key2_level, key3_level | valid/ready
//  result   | out | event_code, sampled_key                   | valid/ready
//  cfg      | in  | cfg_index, cfg_data                       | cfg_we only
//
// one word is taken per cycle while keys is ready; its result is registered into the result queue.
// the result queue holds two words, so keys stays ready while one result waits;
// keys drops ready only when both entries are full.
// rst_n clears the scanner state, the queue and loads the default config.
module key_scan_long_press
(
    input  logic                               clk,
    input  logic                               rst_n,
    ksl_key_if.sink                            keys,
    ksl_result_if.source                       result,
    input  logic                               cfg_we,
    input  logic [ksl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ksl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ksl_pkg::cfg_t    cfg_reg;
    ksl_pkg::item_t   item;
    ksl_pkg::result_t res_new;
    ksl_pkg::result_t buf0_reg, buf1_reg;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_period      <= ksl_pkg::SCAN_PERIOD_RST;
            cfg_reg.long_press_ticks <= ksl_pkg::LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ksl_pkg::REG_SCAN_PERIOD:
                    cfg_reg.scan_period <= cfg_data[ksl_pkg::SCAN_W-1:0];
                ksl_pkg::REG_LONG_PRESS:
                    cfg_reg.long_press_ticks <= cfg_data[ksl_pkg::HOLD_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign item.action     = keys.action;
    assign item.key1_level = keys.key1_level;
    assign item.key2_level = keys.key2_level;
    assign item.key3_level = keys.key3_level;

    assign keys.ready = (cnt_reg != 2'd2);
    assign push       = keys.valid && keys.ready;
    assign pop        = result.valid && result.ready;

    ksl_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (push),
        .item  (item),
        .cfg   (cfg_reg),
        .res   (res_new)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // head word sits in buf0, the waiting one in buf1
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf0_reg <= (cnt_reg == 2'd2) ? buf1_reg : res_new;
            buf1_reg <= res_new;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                buf0_reg <= res_new;
            else
                buf1_reg <= res_new;
        end
    end

    assign result.valid       = (cnt_reg != 2'd0);
    assign result.event_code  = buf0_reg.event_code;
    assign result.sampled_key = buf0_reg.sampled_key;

endmodule
